/* rtl/stl_pkg.sv */
// Shared types and constants for the string-table lexer.
// No dependencies; used by stl_core and string_table_lexer_unit.
package stl_pkg;

  localparam int MAX_ENTRIES = 4096;
  // Hard cap on the entry limit: entry numbers are 12 bits wide.
  localparam int LIMIT_CAP   = (MAX_ENTRIES < 4096) ? MAX_ENTRIES : 4096;
  localparam int RES_MAX     = 5;
  localparam int CNT_W       = $clog2(RES_MAX + 1);

  localparam logic [12:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [3:0] {
    M_OUTSIDE    = 4'd0,
    M_STRING     = 4'd1,
    M_ESCAPE     = 4'd2,
    M_SKIPWS     = 4'd3,
    M_BRACE      = 4'd4,
    M_PAREN_HOLD = 4'd5,
    M_PAREN_CMT  = 4'd6,
    M_SLASH_HOLD = 4'd7,
    M_SLASH_CMT  = 4'd8,
    M_LINE_CMT   = 4'd9,
    M_NULL_HOLD  = 4'd10,
    M_FINISHED   = 4'd11
  } lex_mode_t;

  typedef enum logic [2:0] {
    K_TEXT     = 3'd0,
    K_START    = 3'd1,
    K_END      = 3'd2,
    K_NULL     = 3'd3,
    K_ERROR    = 3'd4,
    K_FINISHED = 3'd5
  } kind_t;

  typedef struct packed {
    lex_mode_t   mode;
    logic        quote_dbl;
    logic        star;
    logic [1:0]  ncount;
    logic [11:0] idx;
    logic        begun;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{
    mode: M_OUTSIDE, quote_dbl: 1'b0, star: 1'b0, ncount: 2'd0, idx: 12'd0, begun: 1'b0
  };

  // Results of one input byte; slot 0 goes out first.
  typedef struct packed {
    kind_t [RES_MAX-1:0]      kind;
    logic  [RES_MAX-1:0][7:0] data;
    logic  [CNT_W-1:0]        cnt;
  } res_list_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UPPER_L = 8'h4C;
  localparam logic [7:0] CH_UPPER_N = 8'h4E;
  localparam logic [7:0] CH_UPPER_U = 8'h55;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

/* rtl/stl_core.sv */
// Next-state and result-list logic of the string-table lexer for one byte.
// Depends on stl_pkg.
module stl_core (
  input  stl_pkg::lex_state_t state,
  input  logic [7:0]          text_byte,
  input  logic                start_of_text,
  input  logic [12:0]         limit,
  output stl_pkg::lex_state_t state_next,
  output stl_pkg::res_list_t  res
);
  import stl_pkg::*;

  typedef struct packed {
    lex_state_t st;
    logic [1:0] n;   // second result, when present, is always finished
    kind_t      k;
    logic [7:0] d;
  } out_step_t;

  // Byte handled in outside-strings mode: at most two results.
  function automatic out_step_t do_outside(input logic [7:0] b, input lex_state_t s,
                                           input logic [12:0] lim);
    out_step_t o;
    logic      ends;
    o = '{st: s, n: 2'd0, k: K_TEXT, d: 8'd0};
    ends = 1'b0;
    if (b == CH_NUL) begin
      o.n = 2'd1;
      o.k = K_FINISHED;
      o.st.mode = M_FINISHED;
    end else if (!is_space(b)) begin
      case (b)
        CH_LBRACE: o.st.mode = M_BRACE;
        CH_LPAREN: o.st.mode = M_PAREN_HOLD;
        CH_SLASH:  o.st.mode = M_SLASH_HOLD;
        CH_HASH: begin
          ends = s.begun;
          o.st.mode = M_LINE_CMT;
        end
        CH_SQUOTE, CH_DQUOTE: begin
          if (!s.begun) begin
            o.n = 2'd1;
            o.k = K_START;
            o.st.begun = 1'b1;
          end
          o.st.quote_dbl = (b == CH_DQUOTE);
          o.st.mode = M_STRING;
        end
        CH_COMMA: ends = 1'b1;
        CH_UPPER_N: begin
          o.st.mode = M_NULL_HOLD;
          o.st.ncount = 2'd0;
        end
        default: begin
          o.n = 2'd1;
          o.k = K_ERROR;
          o.d = b;
        end
      endcase
      if (ends) begin
        o.k = K_END;
        o.st.begun = 1'b0;
        if (({1'b0, s.idx} + 13'd1) >= lim) begin
          o.n = 2'd2;
          o.st.mode = M_FINISHED;
        end else begin
          o.n = 2'd1;
          o.st.idx = s.idx + 12'd1;
        end
      end
    end
    return o;
  endfunction

  lex_state_t      s;
  out_step_t       o;
  logic            go_outside;
  logic            do_string;
  logic [7:0]      quote;
  logic [7:0]      esc;
  logic            match;
  logic [CNT_W-1:0] n;

  always_comb begin
    s = start_of_text ? LEX_RESET : state;
    state_next = s;
    res = '0;
    n = '0;
    go_outside = 1'b0;
    quote = s.quote_dbl ? CH_DQUOTE : CH_SQUOTE;
    esc = text_byte;
    match = 1'b0;
    do_string = (s.mode == M_STRING) || ((s.mode == M_SKIPWS) && !is_space(text_byte));

    if (do_string) begin
      state_next.mode = M_STRING;
      if (text_byte == CH_NUL) begin
        res.kind[n] = K_FINISHED;
        n = n + 1'b1;
        state_next.mode = M_FINISHED;
      end else if (text_byte == quote) begin
        state_next.mode = M_OUTSIDE;
      end else if (text_byte == CH_BSLASH) begin
        state_next.mode = M_ESCAPE;
      end else begin
        res.kind[n] = K_TEXT;
        res.data[n] = text_byte;
        n = n + 1'b1;
      end
    end else begin
      case (s.mode)
        M_OUTSIDE: go_outside = 1'b1;
        M_SKIPWS: ;  // white space after a line continuation
        M_ESCAPE: begin
          if (text_byte == CH_NUL) begin
            res.kind[n] = K_FINISHED;
            n = n + 1'b1;
            state_next.mode = M_FINISHED;
          end else if (text_byte == CH_CR || text_byte == CH_LF) begin
            state_next.mode = M_SKIPWS;
          end else begin
            case (text_byte)
              CH_ZERO:    esc = CH_NUL;
              CH_LOWER_B: esc = CH_BS;
              CH_LOWER_N: esc = CH_LF;
              CH_LOWER_R: esc = CH_CR;
              CH_LOWER_T: esc = CH_TAB;
              default:    esc = text_byte;
            endcase
            res.kind[n] = K_TEXT;
            res.data[n] = esc;
            n = n + 1'b1;
            state_next.mode = M_STRING;
          end
        end
        M_BRACE: begin
          if (text_byte == CH_NUL) begin
            res.kind[n] = K_FINISHED;
            n = n + 1'b1;
            state_next.mode = M_FINISHED;
          end else if (text_byte == CH_RBRACE) begin
            state_next.mode = M_OUTSIDE;
          end
        end
        M_PAREN_HOLD, M_SLASH_HOLD: begin
          if (text_byte == CH_STAR) begin
            state_next.mode = (s.mode == M_PAREN_HOLD) ? M_PAREN_CMT : M_SLASH_CMT;
            state_next.star = 1'b1;
          end else if (s.mode == M_SLASH_HOLD && text_byte == CH_SLASH) begin
            state_next.mode = M_LINE_CMT;
          end else begin
            res.kind[n] = K_ERROR;
            res.data[n] = (s.mode == M_PAREN_HOLD) ? CH_LPAREN : CH_SLASH;
            n = n + 1'b1;
            state_next.mode = M_OUTSIDE;
            go_outside = 1'b1;
          end
        end
        M_PAREN_CMT, M_SLASH_CMT: begin
          // the opening star counts, so "(*)" closes at once
          if (text_byte == CH_NUL) begin
            res.kind[n] = K_FINISHED;
            n = n + 1'b1;
            state_next.mode = M_FINISHED;
          end else if (s.star && text_byte ==
                       ((s.mode == M_PAREN_CMT) ? CH_RPAREN : CH_SLASH)) begin
            state_next.mode = M_OUTSIDE;
            state_next.star = 1'b0;
          end else begin
            state_next.star = (text_byte == CH_STAR);
          end
        end
        M_LINE_CMT: begin
          if (text_byte == CH_NUL) begin
            res.kind[n] = K_FINISHED;
            n = n + 1'b1;
            state_next.mode = M_FINISHED;
          end else if (text_byte == CH_CR || text_byte == CH_LF) begin
            state_next.mode = M_OUTSIDE;
          end
        end
        M_NULL_HOLD: begin
          match = ((s.ncount == 2'd0) && (text_byte == CH_UPPER_U)) ||
                  ((s.ncount == 2'd1) && (text_byte == CH_UPPER_L)) ||
                  ((s.ncount == 2'd2) && (text_byte == CH_UPPER_L));
          if (match) begin
            if (s.ncount == 2'd2) begin
              state_next.ncount = 2'd0;
              state_next.mode = M_OUTSIDE;
              if (!s.begun) begin
                res.kind[n] = K_NULL;
                n = n + 1'b1;
                state_next.begun = 1'b1;
              end
            end else begin
              state_next.ncount = s.ncount + 2'd1;
            end
          end else begin
            // replay the held "N", "U", "L" as errors, then this byte
            state_next.ncount = 2'd0;
            state_next.mode = M_OUTSIDE;
            res.kind[n] = K_ERROR;
            res.data[n] = CH_UPPER_N;
            n = n + 1'b1;
            if (s.ncount != 2'd0) begin
              res.kind[n] = K_ERROR;
              res.data[n] = CH_UPPER_U;
              n = n + 1'b1;
            end
            if (s.ncount[1]) begin
              res.kind[n] = K_ERROR;
              res.data[n] = CH_UPPER_L;
              n = n + 1'b1;
            end
            go_outside = 1'b1;
          end
        end
        default: state_next.mode = M_FINISHED;
      endcase
    end

    o = do_outside(text_byte, state_next, limit);
    if (go_outside) begin
      state_next = o.st;
      if (o.n != 2'd0) begin
        res.kind[n] = o.k;
        res.data[n] = o.d;
        n = n + 1'b1;
      end
      if (o.n == 2'd2) begin
        res.kind[n] = K_FINISHED;
        n = n + 1'b1;
      end
    end
    res.cnt = n;
  end

endmodule

/* rtl/string_table_lexer_unit.sv */
// String-table lexer top level: stream ports, parser state, result buffer.
// Depends on stl_pkg and stl_core.
//
// Takes one text byte per request and returns zero to five results per byte
// (text byte, entry start/end, null entry, syntax error, finished), one result
// per cycle on the output stream while m_tready is high; the last result of a
// byte carries tlast. A byte is accepted every cycle while each byte yields at
// most one result and m_tready is high; a byte with several results holds the
// input until the result buffer has drained. The next byte is taken in the cycle
// the last pending result leaves. Bytes after "finished" give no results
// until a byte arrives with start_of_text set. entry_limit may be written
// only while no results are pending; it is clamped to 1..MAX_ENTRIES, and
// never above 4096.
module string_table_lexer_unit #(
  parameter int MAX_ENTRIES = stl_pkg::MAX_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,       // entry_limit
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,        // [7:0] text_byte
  input  logic        s_tuser,        // [0] start_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,        // [7:0] data_byte, [19:8] entry_number, zero pad
  output logic [2:0]  m_tuser,        // [2:0] kind
  output logic        m_tlast         // last
);
  import stl_pkg::*;

  // Entry numbers are 12 bits wide.
  localparam int ENTRY_CAP = (MAX_ENTRIES < 4096) ? MAX_ENTRIES : 4096;

  logic [12:0]              entry_limit;
  logic [12:0]              limit;
  lex_state_t               state;
  lex_state_t               state_next;
  res_list_t                res_next;
  kind_t [RES_MAX-1:0]      buf_kind;
  logic  [RES_MAX-1:0][7:0] buf_data;
  logic [11:0]              buf_idx;
  logic [CNT_W-1:0]         pending;
  logic                     accept;
  logic                     pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    limit = entry_limit;
    if (limit == 13'd0) limit = 13'd1;
    if (limit > 13'(ENTRY_CAP)) limit = 13'(ENTRY_CAP);
  end

  stl_core u_core (
    .state         (state),
    .text_byte     (s_tdata),
    .start_of_text (s_tuser),
    .limit         (limit),
    .state_next    (state_next),
    .res           (res_next)
  );

  assign pop      = m_tvalid && m_tready;
  assign s_tready = (pending == '0) || ((pending == CNT_W'(1)) && m_tready);
  assign accept   = s_tvalid && s_tready;

  assign m_tvalid = (pending != '0);
  assign m_tlast  = (pending == CNT_W'(1));
  assign m_tuser  = buf_kind[0];
  assign m_tdata  = {4'b0000, buf_idx, buf_data[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= LIMIT_RESET;
      state       <= LEX_RESET;
      pending     <= '0;
    end else begin
      if (cfg_valid) entry_limit <= cfg_data;
      if (accept) begin
        state   <= state_next;
        pending <= res_next.cnt;
      end else if (pop) begin
        pending <= pending - 1'b1;
      end
    end
  end

  // Payload: all results of one byte share the entry number at its arrival.
  always_ff @(posedge clk) begin
    if (accept) begin
      buf_kind <= res_next.kind;
      buf_data <= res_next.data;
      buf_idx  <= s_tuser ? 12'd0 : state.idx;
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        buf_kind[i] <= buf_kind[i+1];
        buf_data[i] <= buf_data[i+1];
      end
    end
  end

endmodule
